// ===== design/rrct_pkg.sv =====
// ---------------------------------------------------------------------------
// RF remote code transmitter package
// Shared word types, control structs and constants for the on-off keyed
// remote code transmitter.
// ---------------------------------------------------------------------------
package rrct_pkg;

    // Field and register widths.
    localparam int CODE_W   = 24;
    localparam int REPEAT_W = 8;
    localparam int IDX_W    = 2;
    localparam int CFG_W    = 24;
    localparam int NUM_CODES = 3;

    // Frame timing, in ticks.
    localparam int TICK_W      = 7;
    localparam int SYNC_END    = 32;
    localparam int BIT_OFFSET  = 28;

    // Item kinds.
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    // Request code indexes.
    localparam logic [IDX_W-1:0] IDX_OPEN    = 2'd0;
    localparam logic [IDX_W-1:0] IDX_CLOSE   = 2'd1;
    localparam logic [IDX_W-1:0] IDX_STOP    = 2'd2;
    localparam logic [IDX_W-1:0] IDX_INVALID = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CODE_WORD_0  = 2'd0;
    localparam logic [1:0] CFG_CODE_WORD_1  = 2'd1;
    localparam logic [1:0] CFG_CODE_WORD_2  = 2'd2;
    localparam logic [1:0] CFG_REPEAT_COUNT = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CODE_W-1:0]   RST_CODE_WORD_0  = 24'hE7AAA1;
    localparam logic [CODE_W-1:0]   RST_CODE_WORD_1  = 24'hE7AAA8;
    localparam logic [CODE_W-1:0]   RST_CODE_WORD_2  = 24'hE7AAA4;
    localparam logic [REPEAT_W-1:0] RST_REPEAT_COUNT = 8'd8;

    typedef logic [CODE_W-1:0]   t_code;
    typedef logic [REPEAT_W-1:0] t_repeat;
    typedef logic [IDX_W-1:0]    t_idx;

    // Input word.
    typedef struct packed {
        logic kind;
        t_idx code_index;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic request_dropped;
    } t_out_word;

    // Queue control from the frame engine.
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_q_ctrl;

    // Queue status to the frame engine.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// ===== design/rrct_queue.sv =====
// ---------------------------------------------------------------------------
// Pending request queue
// Small shifting FIFO of code indexes; the head is always entry zero.
// ---------------------------------------------------------------------------
module rrct_queue
    import rrct_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_ctrl i_ctrl,
    input  t_idx    i_data,
    output t_idx    o_head,
    output t_q_stat o_stat
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    t_idx          r_mem [DEPTH];

    // Fill count.
    always_comb begin
        n_count = r_count;
        if (i_ctrl.clear) begin
            n_count = '0;
        end else if (i_ctrl.push) begin
            n_count = r_count + CW'(1);
        end else if (i_ctrl.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Storage: write at the fill count, shift down on a pop.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_count[AW-1:0]] <= i_data;
        end else if (i_ctrl.pop) begin
            for (int k = 1; k < DEPTH; k++) begin
                r_mem[k-1] <= r_mem[k];
            end
        end
    end

    assign o_head       = r_mem[0];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");

    // A pop or a push never goes past the ends of the queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.pop && !i_ctrl.clear) |-> (r_count != '0))
        else $error("pop from empty queue");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.push |-> (r_count != CW'(DEPTH)))
        else $error("push into full queue");

endmodule

// ===== design/rrct_engine.sv =====
// ---------------------------------------------------------------------------
// Frame engine
// Holds the transmit state and works out the line level, the next state and
// the result word for one item in a single pass.
// ---------------------------------------------------------------------------
module rrct_engine
    import rrct_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  t_in_word                i_item,
    input  t_code [NUM_CODES-1:0]   i_code_words,
    input  t_repeat                 i_repeat_count,
    input  t_idx                    i_q_head,
    input  t_q_stat                 i_q_stat,
    output t_q_ctrl                 o_q_ctrl,
    output t_out_word               o_res
);

    logic [TICK_W-1:0] r_tick;
    logic [TICK_W-1:0] n_tick;
    t_repeat           r_repeats;
    t_repeat           n_repeats;
    t_idx              r_active;
    t_idx              n_active;
    logic              r_sending;
    logic              n_sending;
    logic              r_level;
    logic              n_level;

    logic [TICK_W:0]   t_next;
    logic [TICK_W-1:0] t_rel;
    logic [4:0]        bit_pos;
    t_code             word;
    logic              code_bit;
    logic [1:0]        phase;
    t_repeat           rep_dec;
    logic              dropped;

    // Code word of the active request, read live.
    always_comb begin
        case (r_active)
            IDX_OPEN:  word = i_code_words[0];
            IDX_CLOSE: word = i_code_words[1];
            default:   word = i_code_words[2];
        endcase
    end

    // Position within the frame after this tick and the data bit it covers.
    assign t_next   = {1'b0, r_tick} + (TICK_W + 1)'(1);
    assign t_rel    = t_next[TICK_W-1:0] - TICK_W'(BIT_OFFSET);
    assign bit_pos  = 5'd24 - t_rel[6:2];
    assign phase    = t_next[1:0];
    assign code_bit = (bit_pos < 5'd24) ? word[bit_pos] : 1'b0;
    assign rep_dec  = r_repeats - REPEAT_W'(1);

    // Next state and result for the item in the input register.
    always_comb begin
        n_tick    = r_tick;
        n_repeats = r_repeats;
        n_active  = r_active;
        n_sending = r_sending;
        n_level   = r_level;
        o_q_ctrl  = '0;
        dropped   = 1'b0;
        if (i_fire) begin
            if (i_item.kind == KIND_TICK) begin
                if (r_sending) begin
                    if (t_next[TICK_W]) begin
                        // End of a frame: repeat, take the next request or stop.
                        n_tick    = '0;
                        n_repeats = rep_dec;
                        if (rep_dec != '0) begin
                            n_level = 1'b1;
                        end else begin
                            n_sending = 1'b0;
                            n_level   = 1'b0;
                            if (!i_q_stat.empty) begin
                                n_active = i_q_head;
                                if (i_repeat_count != '0) begin
                                    o_q_ctrl.pop = 1'b1;
                                    n_repeats    = i_repeat_count;
                                    n_sending    = 1'b1;
                                    n_level      = 1'b1;
                                end else begin
                                    // Every queued request sends nothing.
                                    o_q_ctrl.clear = 1'b1;
                                end
                            end
                        end
                    end else begin
                        n_tick = t_next[TICK_W-1:0];
                        if (t_next[TICK_W-1:0] == TICK_W'(1)) begin
                            n_level = 1'b0;
                        end else if (t_next[TICK_W-1:0] == TICK_W'(SYNC_END)) begin
                            n_level = 1'b1;
                        end else if (t_next[TICK_W-1:0] > TICK_W'(SYNC_END)) begin
                            if (phase == 2'd0) begin
                                n_level = 1'b1;
                            end else if (code_bit ? (phase == 2'd3) : (phase == 2'd1)) begin
                                n_level = 1'b0;
                            end
                        end
                    end
                end
            end else if (i_item.code_index == IDX_INVALID) begin
                dropped = 1'b1;
            end else if (!r_sending) begin
                n_active  = i_item.code_index;
                n_repeats = i_repeat_count;
                n_tick    = '0;
                n_sending = (i_repeat_count != '0);
                n_level   = (i_repeat_count != '0);
            end else if (!i_q_stat.full) begin
                o_q_ctrl.push = 1'b1;
            end else begin
                dropped = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= '0;
            r_repeats <= '0;
            r_active  <= IDX_OPEN;
            r_sending <= 1'b0;
            r_level   <= 1'b0;
        end else begin
            r_tick    <= n_tick;
            r_repeats <= n_repeats;
            r_active  <= n_active;
            r_sending <= n_sending;
            r_level   <= n_level;
        end
    end

    assign o_res.line_level      = n_level;
    assign o_res.busy_res        = n_sending;
    assign o_res.request_dropped = dropped;

    // A sequence in progress always has frames left to send.
    a_repeats_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sending |-> (r_repeats != '0))
        else $error("sending with no repeats left");

    // While idle the line is low and the frame position is at its start.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> (!r_level && (r_tick == '0)))
        else $error("idle line not quiet");

    // Requests queue up only while sending, and the queue drains only on a tick.
    a_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_q_ctrl.push && (o_q_ctrl.pop || o_q_ctrl.clear)))
        else $error("queue push and pop together");

endmodule

// ===== design/rf_remote_code_transmitter_top.sv =====
// ---------------------------------------------------------------------------
// RF remote code transmitter
// A word accepted on the input channel is held in the input register; its
// result then goes to the result register, which drives o_out_data.
// Throughput: one word per cycle; the frame engine settles each word in a
// single combinational pass, so stalls come only from the result side.
// Reset: synchronous, active low; clears the transmit state, the queue fill
// count, both valid flags and loads the default code words and repeat count.
// ---------------------------------------------------------------------------
module rf_remote_code_transmitter_top
    import rrct_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Input channel.
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_data,
    // Result channel.
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_data,
    // Configuration write port.
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_code [NUM_CODES-1:0] r_code_words;
    t_repeat               r_repeat_count;

    logic      r_in_valid;
    t_in_word  r_in_data;
    logic      r_out_valid;
    t_out_word r_out_data;

    logic      fire;
    t_out_word res;
    t_q_ctrl   q_ctrl;
    t_q_stat   q_stat;
    t_idx      q_head;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_words[0] <= RST_CODE_WORD_0;
            r_code_words[1] <= RST_CODE_WORD_1;
            r_code_words[2] <= RST_CODE_WORD_2;
            r_repeat_count  <= RST_REPEAT_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CODE_WORD_0:  r_code_words[0] <= i_cfg_data[CODE_W-1:0];
                CFG_CODE_WORD_1:  r_code_words[1] <= i_cfg_data[CODE_W-1:0];
                CFG_CODE_WORD_2:  r_code_words[2] <= i_cfg_data[CODE_W-1:0];
                CFG_REPEAT_COUNT: r_repeat_count  <= i_cfg_data[REPEAT_W-1:0];
                default:          r_repeat_count  <= r_repeat_count;
            endcase
        end
    end

    // The engine takes the held word whenever the result register is free.
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_data <= i_in_data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    rrct_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_item         (r_in_data),
        .i_code_words   (r_code_words),
        .i_repeat_count (r_repeat_count),
        .i_q_head       (q_head),
        .i_q_stat       (q_stat),
        .o_q_ctrl       (q_ctrl),
        .o_res          (res)
    );

    rrct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .i_data  (r_in_data.code_index),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

endmodule

// ===== tb/tb_rf_remote_code_transmitter_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// RF remote code transmitter testbench
// Feeds tick and request words through the valid/stall input channel and
// checks every result word against an in-bench frame predictor. A directed
// opening covers idle ticks, invalid and dropped requests, a zero repeat
// count, queued hand-off and extreme code words. Random phases then vary the
// code words, the repeat count and the idling of both channels.
// ---------------------------------------------------------------------------
module tb_rf_remote_code_transmitter_top;
    import rrct_pkg::*;

    localparam int QUEUE_DEPTH    = 2;
    localparam int FRAME_TICKS    = 128;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    t_in_word         i_in_data  = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_word        o_out_data;
    logic             i_cfg_we   = 1'b0;
    logic [1:0]       i_cfg_idx  = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    rf_remote_code_transmitter_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 4 ns clock.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Words waiting to be sent and line states owed by the block.
    t_in_word  pend_words [$];
    t_out_word owed_line_states [$];

    // Predictor copy of the registers and the transmit state.
    t_code       m_code [NUM_CODES];
    t_repeat     m_repeat_cfg;
    logic [7:0]  m_tick;
    logic [7:0]  m_reps_left;
    t_idx        m_active;
    logic        m_sending;
    logic        m_level;
    t_idx        m_pending [$];

    // Run statistics.
    int unsigned n_words_in   = 0;
    int unsigned n_requests   = 0;
    int unsigned n_dropped    = 0;
    int unsigned n_results    = 0;
    int unsigned n_errors     = 0;
    int unsigned n_settings   = 0;

    // Idling controls.
    logic        send_calm = 1'b0;
    logic        recv_calm = 1'b0;
    int unsigned drv_gap   = 0;
    int unsigned rcv_wait  = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    // Start a code sequence; a zero repeat count leaves the block idle.
    function automatic void launch_code(t_idx idx);
        m_active    = idx;
        m_reps_left = m_repeat_cfg;
        m_tick      = '0;
        m_sending   = (m_repeat_cfg != '0);
        m_level     = m_sending;
    endfunction

    // One pulse-unit tick of the frame engine.
    function automatic void advance_tick();
        int unsigned t;
        int unsigned phase;
        int unsigned bitpos;
        logic        code_bit;
        if (!m_sending) return;
        t = m_tick + 1;
        if (t >= FRAME_TICKS) begin
            m_tick = '0;
            if (m_reps_left != '0) m_reps_left--;
            if (m_reps_left != '0) begin
                m_level = 1'b1;
            end else begin
                // Last frame done: the oldest queued request starts on this tick.
                m_sending = 1'b0;
                m_level   = 1'b0;
                while (!m_sending && m_pending.size() > 0)
                    launch_code(m_pending.pop_front());
            end
            return;
        end
        m_tick = t[7:0];
        if (t == 1) begin
            m_level = 1'b0;
        end else if (t == SYNC_END) begin
            m_level = 1'b1;
        end else if (t > SYNC_END) begin
            phase = t % 4;
            if (phase == 0) begin
                m_level = 1'b1;
            end else begin
                bitpos   = CODE_W - ((t - BIT_OFFSET) >> 2);
                code_bit = m_code[m_active][bitpos];
                if (code_bit ? (phase == 3) : (phase == 1)) m_level = 1'b0;
            end
        end
    endfunction

    // Expected result word for one accepted input word.
    function automatic t_out_word encode_step(t_in_word w);
        t_out_word r;
        logic      drop;
        drop = 1'b0;
        if (w.kind == KIND_TICK) begin
            advance_tick();
        end else if (w.code_index == IDX_INVALID) begin
            drop = 1'b1;
        end else if (!m_sending) begin
            launch_code(w.code_index);
        end else if (m_pending.size() < QUEUE_DEPTH) begin
            m_pending.push_back(w.code_index);
        end else begin
            drop = 1'b1;
        end
        r.line_level      = m_level;
        r.busy_res        = m_sending;
        r.request_dropped = drop;
        return r;
    endfunction

    // Sender: presents queued words with a random gap before each one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            drv_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                owed_line_states.push_back(encode_step(i_in_data));
                n_words_in++;
                if (i_in_data.kind == KIND_REQUEST) n_requests++;
                if (owed_line_states[$].request_dropped) n_dropped++;
                drv_gap = send_calm ? 0 : $urandom_range(0, 8);
            end
            // A stalled word stays put; otherwise pick the next one or idle.
            if (!i_in_valid || !o_in_stall) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    i_in_valid <= 1'b0;
                end else if (pend_words.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pend_words.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted result and draws its own stalls.
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (owed_line_states.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("[mon] unexpected result %0d: level %b busy %b dropped %b",
                                 n_results, o_out_data.line_level, o_out_data.busy_res,
                                 o_out_data.request_dropped);
                end else begin
                    want = owed_line_states.pop_front();
                    if (want.line_level !== o_out_data.line_level
                            || want.busy_res !== o_out_data.busy_res
                            || want.request_dropped !== o_out_data.request_dropped) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display({"[mon] result %0d mismatch: level exp %b got %b,",
                                      " busy exp %b got %b, dropped exp %b got %b"},
                                     n_results, want.line_level, o_out_data.line_level,
                                     want.busy_res, o_out_data.busy_res,
                                     want.request_dropped, o_out_data.request_dropped);
                    end
                end
                rcv_wait = recv_calm ? 0 : $urandom_range(0, 8);
                // One long hold-off while the sender still has plenty to offer.
                if (!hold_done && n_results >= 300 && pend_words.size() > 50) begin
                    hold_done = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (rcv_wait > 0) begin
                rcv_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no traffic at all.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall)
                    || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("[tb] no traffic for %0d cycles, %0d results still owed",
                 WATCHDOG_LIMIT, owed_line_states.size());
        $display("tb: failure");
        $finish;
    end

    function automatic void put_word(logic kind, t_idx idx);
        t_in_word w;
        w.kind       = kind;
        w.code_index = idx;
        pend_words.push_back(w);
    endfunction

    // Ticks carry a random index, which the block ignores.
    function automatic void put_ticks(int unsigned n);
        for (int k = 0; k < n; k++) put_word(KIND_TICK, t_idx'($urandom_range(0, 3)));
    endfunction

    // Wait until every word is sent and every result has come back.
    task automatic settle();
        do @(negedge i_clk);
        while (pend_words.size() != 0 || i_in_valid || owed_line_states.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Tick the block until it has sent every queued frame.
    task automatic run_out_frames();
        while (m_sending) begin
            put_ticks(32);
            settle();
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_CODE_WORD_0:  m_code[0]    = value[CODE_W-1:0];
            CFG_CODE_WORD_1:  m_code[1]    = value[CODE_W-1:0];
            CFG_CODE_WORD_2:  m_code[2]    = value[CODE_W-1:0];
            CFG_REPEAT_COUNT: m_repeat_cfg = value[REPEAT_W-1:0];
            default: ;
        endcase
        n_settings++;
    endtask

    // Random code words, now and then at an extreme.
    task automatic write_random_codes();
        logic [CFG_W-1:0] value;
        for (int k = 0; k < NUM_CODES; k++) begin
            case ($urandom_range(0, 5))
                0:       value = '0;
                1:       value = '1;
                default: value = CFG_W'($urandom);
            endcase
            write_reg(2'(k), value);
        end
    endtask

    // Mostly ticks with requests sprinkled in; rare bursts overflow the queue.
    task automatic queue_random_words(int unsigned n);
        t_idx idx;
        @(negedge i_clk);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 199) == 0) begin
                for (int j = 0; j < 4; j++) put_word(KIND_REQUEST, t_idx'($urandom_range(0, 3)));
            end else if ($urandom_range(0, 99) < 3) begin
                idx = ($urandom_range(0, 11) == 0) ? IDX_INVALID : t_idx'($urandom_range(0, 2));
                put_word(KIND_REQUEST, idx);
            end else begin
                put_ticks(1);
            end
        end
        settle();
    endtask

    initial begin
        logic [REPEAT_W-1:0] reps;
        m_code[0]    = RST_CODE_WORD_0;
        m_code[1]    = RST_CODE_WORD_1;
        m_code[2]    = RST_CODE_WORD_2;
        m_repeat_cfg = RST_REPEAT_COUNT;
        m_tick       = '0;
        m_reps_left  = '0;
        m_active     = IDX_OPEN;
        m_sending    = 1'b0;
        m_level      = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: idle tick, invalid request while idle, one full
        // eight-frame sequence with an invalid request dropped while busy.
        @(negedge i_clk);
        put_ticks(1);
        put_word(KIND_REQUEST, IDX_INVALID);
        put_word(KIND_REQUEST, IDX_STOP);
        put_word(KIND_REQUEST, IDX_INVALID);
        put_ticks(8 * FRAME_TICKS + 2);
        settle();
        run_out_frames();

        // Zero repeat count: requests are taken but nothing is sent.
        write_reg(CFG_REPEAT_COUNT, '0);
        write_reg(CFG_CODE_WORD_0, '0);
        write_reg(CFG_CODE_WORD_1, '1);
        write_reg(CFG_CODE_WORD_2, 24'h800001);
        @(negedge i_clk);
        put_word(KIND_REQUEST, IDX_OPEN);
        put_ticks(1);
        put_word(KIND_REQUEST, IDX_CLOSE);
        put_word(KIND_REQUEST, IDX_STOP);
        put_ticks(1);
        put_word(KIND_REQUEST, IDX_INVALID);
        settle();

        // One frame per request: two queued behind the first, the rest
        // dropped on a full queue; each hand-off goes straight back high.
        write_reg(CFG_REPEAT_COUNT, 24'd1);
        @(negedge i_clk);
        put_word(KIND_REQUEST, IDX_OPEN);
        put_word(KIND_REQUEST, IDX_CLOSE);
        put_word(KIND_REQUEST, IDX_STOP);
        put_word(KIND_REQUEST, IDX_OPEN);
        put_word(KIND_REQUEST, IDX_INVALID);
        put_word(KIND_REQUEST, IDX_CLOSE);
        put_ticks(3 * FRAME_TICKS + 3);
        settle();
        run_out_frames();

        // Random phases with varying registers and idling. A sequence may
        // still be running when the registers change between phases.
        for (int p = 0; p < 5; p++) begin
            case ($urandom_range(0, 4))
                0:       reps = 8'd0;
                1:       reps = 8'd3;
                2:       reps = 8'd2;
                default: reps = 8'd1;
            endcase
            write_reg(CFG_REPEAT_COUNT, {16'($urandom), reps});
            write_random_codes();
            send_calm = (p % 3 == 1);
            recv_calm = (p % 3 == 2);
            queue_random_words(40);
        end

        // Largest repeat count: only the opening frames are sent.
        write_reg(CFG_REPEAT_COUNT, {16'($urandom), 8'd255});
        write_random_codes();
        send_calm = 1'b0;
        recv_calm = 1'b0;
        queue_random_words(30);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("[tb] %0d words in (%0d requests, %0d dropped), %0d results checked",
                 n_words_in, n_requests, n_dropped, n_results);
        $display("[tb] %0d register writes, %0d mismatches", n_settings, n_errors);
        if (n_errors == 0 && owed_line_states.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
